// ===== hw/rtl/cbap_pkg.sv =====
// ----------------------------------------------------------------------------
// cbap_pkg
// shared types and constants for the cascaded balance angle controller
// ----------------------------------------------------------------------------
package cbap_pkg;

	// configuration port geometry
	localparam int unsigned CFG_AW = 5;
	localparam int unsigned CFG_DW = 32;

	// low-pass weights in Q.16, old sample and new sample
	localparam logic signed [31:0] W_OLD = 32'sd26214;
	localparam logic signed [31:0] W_NEW = 32'sd39322;

	typedef struct packed {
		logic signed [23:0] tilt_angle;
		logic signed [23:0] pitch_rate;
		logic               run;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] drive;
		logic               outer_updated;
	} result_t;

	typedef struct packed {
		logic signed [23:0] angle_setpoint;
		logic signed [31:0] angle_kp;
		logic signed [31:0] angle_ki;
		logic signed [31:0] angle_kd;
		logic signed [31:0] rate_kp;
		logic signed [31:0] rate_ki;
		logic signed [31:0] rate_kd;
		logic        [22:0] drive_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		angle_setpoint: 24'sd11776,
		angle_kp:       -32'sd6291456,
		angle_ki:       32'sd0,
		angle_kd:       32'sd1638400,
		rate_kp:        32'sd235930,
		rate_ki:        32'sd0,
		rate_kd:        32'sd43254,
		drive_limit:    23'h7FFFFF
	};

	typedef enum logic [2:0] {
		REG_ANGLE_SETPOINT,
		REG_ANGLE_KP,
		REG_ANGLE_KI,
		REG_ANGLE_KD,
		REG_RATE_KP,
		REG_RATE_KI,
		REG_RATE_KD,
		REG_DRIVE_LIMIT
	} reg_idx_t;

	// operand pair for the shared multiplier
	typedef enum logic [2:0] {
		MS_ANGLE_KI,
		MS_ANGLE_KP,
		MS_ANGLE_KD,
		MS_W_OLD,
		MS_W_NEW,
		MS_RATE_KI,
		MS_RATE_KP,
		MS_RATE_KD
	} mul_sel_t;

	// what to do with the product registered in the previous cycle
	typedef enum logic [3:0] {
		CO_NONE,
		CO_ANGLE_INT,
		CO_ACC_AINT,
		CO_OUTER,
		CO_ACC_RAW,
		CO_FILT,
		CO_RATE_INT,
		CO_ACC_RINT,
		CO_SUM
	} cons_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		cons_op_t cons_op;
		logic     ld_in;
		logic     ld_diff;
		logic     ld_delta;
		logic     ld_out;
		logic     upd;
	} dp_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AKI,
		ST_AKP,
		ST_AKD,
		ST_OUT,
		ST_FOLD,
		ST_DIFF,
		ST_FNEW,
		ST_FILT,
		ST_RKI,
		ST_RKP,
		ST_RKD,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/cascaded_balance_angle_pid.sv =====
// ----------------------------------------------------------------------------
// cascaded_balance_angle_pid
// Cascaded tilt-angle and pitch-rate PID for a self-balancing body. Each
// request carries one control tick (tilt angle, pitch rate, run flag, all
// values signed Q.8, gains signed Q.16) and produces exactly one result: the
// drive value clamped to +-drive_limit and a flag that marks ticks on which
// the outer angle loop ran. The outer loop runs on every OUTER_DIVIDE-th
// tick; the inner loop low-pass filters its error and runs on every running
// tick; with run low the last drive is repeated and only the tick counter
// moves. All products go through one shared 32x32 multiplier stepped by a
// sequencer. On inner-only ticks the sequencer skips the outer-loop states,
// and with run low it goes straight to the output register. A new request
// is taken once the previous one has reached the output register, even
// while that result still waits to be taken. Registers sit on an APB-style
// port at byte address 4*index; writes are expected only while the block is
// idle.
// ----------------------------------------------------------------------------
module cascaded_balance_angle_pid import cbap_pkg::*; #(
	parameter int unsigned OUTER_DIVIDE = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	// control tick request
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	// drive result
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	dp_cmd_t  cmd;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
			REG_ANGLE_SETPOINT: cfg_q.angle_setpoint <= pwdata[23:0];
			REG_ANGLE_KP:       cfg_q.angle_kp       <= pwdata;
			REG_ANGLE_KI:       cfg_q.angle_ki       <= pwdata;
			REG_ANGLE_KD:       cfg_q.angle_kd       <= pwdata;
			REG_RATE_KP:        cfg_q.rate_kp        <= pwdata;
			REG_RATE_KI:        cfg_q.rate_ki        <= pwdata;
			REG_RATE_KD:        cfg_q.rate_kd        <= pwdata;
			REG_DRIVE_LIMIT:    cfg_q.drive_limit    <= pwdata[22:0];
			default: ;
			endcase
		end
	end

	// read back the raw register bits
	always_comb begin
		case (reg_idx)
		REG_ANGLE_SETPOINT: prdata = {8'b0, cfg_q.angle_setpoint};
		REG_ANGLE_KP:       prdata = cfg_q.angle_kp;
		REG_ANGLE_KI:       prdata = cfg_q.angle_ki;
		REG_ANGLE_KD:       prdata = cfg_q.angle_kd;
		REG_RATE_KP:        prdata = cfg_q.rate_kp;
		REG_RATE_KI:        prdata = cfg_q.rate_ki;
		REG_RATE_KD:        prdata = cfg_q.rate_kd;
		REG_DRIVE_LIMIT:    prdata = {9'b0, cfg_q.drive_limit};
		default:            prdata = '0;
		endcase
	end

	// sequencer: tick divider, multiplier schedule, request/result handshake
	cbap_ctrl #(
		.OUTER_DIVIDE(OUTER_DIVIDE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_run   (sample.run),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	// arithmetic: shared multiplier, integrators, filter, clamps
	cbap_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.sample (sample),
		.cmd    (cmd),
		.result (result)
	);

	// a taken request always makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("request accepted but block not busy afterwards");

	// the sample is latched only on an accepted request
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_in |-> (sample_valid && !sample_stall))
		else $error("sample latched without an accepted request");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!result_valid || !result_stall))
		else $error("output register loaded over a stalled result");

endmodule

// ===== hw/rtl/cbap_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbap_ctrl
// sequencer for the shared multiplier, tick divider and result handshake
// ----------------------------------------------------------------------------
module cbap_ctrl import cbap_pkg::*; #(
	parameter int unsigned OUTER_DIVIDE = 5
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	input  logic    sample_run,
	output logic    sample_stall,
	output logic    result_valid,
	input  logic    result_stall,
	output dp_cmd_t cmd
);

	localparam int unsigned TW = $clog2(OUTER_DIVIDE + 1);
	localparam logic [TW:0] DIV = OUTER_DIVIDE[TW:0];

	state_t        state_q, state_n;
	logic [TW-1:0] tick_q, tick_n;
	logic [TW:0]   tick_inc, tick_sat;
	logic          upd_q, upd_n;
	logic          result_valid_q, result_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tick_q         <= '0;
			upd_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_n;
			tick_q         <= tick_n;
			upd_q          <= upd_n;
			result_valid_q <= result_valid_n;
		end
	end

	// tick counter saturates at the divide ratio
	assign tick_inc = {1'b0, tick_q} + {{TW{1'b0}}, 1'b1};
	assign tick_sat = (tick_inc > DIV) ? DIV : tick_inc;

	always_comb begin
		state_n        = state_q;
		tick_n         = tick_q;
		upd_n          = upd_q;
		result_valid_n = result_valid_q && result_stall;
		cmd.mul_sel    = MS_ANGLE_KI;
		cmd.cons_op    = CO_NONE;
		cmd.ld_in      = 1'b0;
		cmd.ld_diff    = 1'b0;
		cmd.ld_delta   = 1'b0;
		cmd.ld_out     = 1'b0;
		cmd.upd        = upd_q;
		case (state_q)
		ST_IDLE: begin
			if (sample_valid) begin
				cmd.ld_in = 1'b1;
				upd_n     = 1'b0;
				tick_n    = tick_sat[TW-1:0];
				if (sample_run) begin
					if (tick_sat == DIV) begin
						tick_n  = '0;
						upd_n   = 1'b1;
						state_n = ST_AKI;
					end else begin
						state_n = ST_FOLD;
					end
				end else begin
					state_n = ST_DONE;
				end
			end
		end
		ST_AKI: begin
			cmd.mul_sel = MS_ANGLE_KI;
			state_n     = ST_AKP;
		end
		ST_AKP: begin
			cmd.mul_sel = MS_ANGLE_KP;
			cmd.cons_op = CO_ANGLE_INT;
			state_n     = ST_AKD;
		end
		ST_AKD: begin
			cmd.mul_sel = MS_ANGLE_KD;
			cmd.cons_op = CO_ACC_AINT;
			state_n     = ST_OUT;
		end
		ST_OUT: begin
			cmd.mul_sel = MS_W_OLD;
			cmd.cons_op = CO_OUTER;
			state_n     = ST_DIFF;
		end
		ST_FOLD: begin
			cmd.mul_sel = MS_W_OLD;
			state_n     = ST_DIFF;
		end
		ST_DIFF: begin
			cmd.ld_diff = 1'b1;
			cmd.cons_op = CO_ACC_RAW;
			state_n     = ST_FNEW;
		end
		ST_FNEW: begin
			cmd.mul_sel = MS_W_NEW;
			state_n     = ST_FILT;
		end
		ST_FILT: begin
			cmd.cons_op = CO_FILT;
			state_n     = ST_RKI;
		end
		ST_RKI: begin
			cmd.mul_sel  = MS_RATE_KI;
			cmd.ld_delta = 1'b1;
			state_n      = ST_RKP;
		end
		ST_RKP: begin
			cmd.mul_sel = MS_RATE_KP;
			cmd.cons_op = CO_RATE_INT;
			state_n     = ST_RKD;
		end
		ST_RKD: begin
			cmd.mul_sel = MS_RATE_KD;
			cmd.cons_op = CO_ACC_RINT;
			state_n     = ST_SUM;
		end
		ST_SUM: begin
			cmd.cons_op = CO_SUM;
			state_n     = ST_DONE;
		end
		ST_DONE: begin
			if (!result_valid_q || !result_stall) begin
				cmd.ld_out     = 1'b1;
				result_valid_n = 1'b1;
				state_n        = ST_IDLE;
			end
		end
		default: begin
			state_n = ST_IDLE;
		end
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

// ===== hw/rtl/cbap_dpath.sv =====
// ----------------------------------------------------------------------------
// cbap_dpath
// shared multiplier, accumulator and loop state of both pid stages
// ----------------------------------------------------------------------------
module cbap_dpath import cbap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  sample_t sample,
	input  dp_cmd_t cmd,
	output result_t result
);

	localparam logic signed [48:0] AINT_HI = 49'sd1280;
	localparam logic signed [48:0] AINT_LO = -49'sd1280;
	localparam logic signed [48:0] RINT_HI = 49'sd512000;
	localparam logic signed [48:0] RINT_LO = -49'sd512000;
	localparam logic signed [63:0] S32_HI  = 64'sd2147483647;
	localparam logic signed [63:0] S32_LO  = -64'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > S32_HI)
			r = S32_HI[31:0];
		else if (x < S32_LO)
			r = S32_LO[31:0];
		else
			r = x[31:0];
		return r;
	endfunction

	// loop state
	logic signed [11:0] aint_q;
	logic signed [31:0] outer_q;
	logic signed [31:0] filt_q;
	logic signed [31:0] fold_q;
	logic signed [19:0] rint_q;
	logic signed [23:0] hold_q;

	// per-item working registers
	logic signed [24:0] err_q;
	logic signed [23:0] rate_q;
	logic signed [63:0] prod_s1;
	logic signed [63:0] acc_q;
	logic signed [31:0] diff_q;
	logic signed [31:0] delta_q;
	result_t            result_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] rsum;
	logic signed [47:0] rnd;
	logic signed [63:0] rnd64;
	logic signed [48:0] aint_sum, rint_sum;
	logic signed [63:0] outer_sum, fsum, dsum;
	logic signed [63:0] lim_pos, lim_neg;

	always_comb begin
		case (cmd.mul_sel)
		MS_ANGLE_KI: begin mul_a = cfg.angle_ki; mul_b = {{7{err_q[24]}}, err_q}; end
		MS_ANGLE_KP: begin mul_a = cfg.angle_kp; mul_b = {{7{err_q[24]}}, err_q}; end
		MS_ANGLE_KD: begin mul_a = cfg.angle_kd; mul_b = {{8{rate_q[23]}}, rate_q}; end
		MS_W_OLD:    begin mul_a = W_OLD;        mul_b = filt_q; end
		MS_W_NEW:    begin mul_a = W_NEW;        mul_b = diff_q; end
		MS_RATE_KI:  begin mul_a = cfg.rate_ki;  mul_b = filt_q; end
		MS_RATE_KP:  begin mul_a = cfg.rate_kp;  mul_b = filt_q; end
		MS_RATE_KD:  begin mul_a = cfg.rate_kd;  mul_b = delta_q; end
		default:     begin mul_a = cfg.angle_ki; mul_b = {{7{err_q[24]}}, err_q}; end
		endcase
	end

	// gain product rounded half up back to q.8
	assign rsum  = prod_s1 + 64'sd32768;
	assign rnd   = rsum[63:16];
	assign rnd64 = {{16{rnd[47]}}, rnd};

	assign aint_sum  = {{37{aint_q[11]}}, aint_q} + {rnd[47], rnd};
	assign rint_sum  = {{29{rint_q[19]}}, rint_q} + {rnd[47], rnd};
	assign outer_sum = acc_q + rnd64;
	assign fsum      = acc_q + prod_s1 + 64'sd32768;
	assign dsum      = acc_q + rnd64;
	assign lim_pos   = {41'b0, cfg.drive_limit};
	assign lim_neg   = -lim_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aint_q  <= '0;
			outer_q <= '0;
			filt_q  <= '0;
			fold_q  <= '0;
			rint_q  <= '0;
			hold_q  <= '0;
		end else begin
			case (cmd.cons_op)
			CO_ANGLE_INT: begin
				if (aint_sum > AINT_HI)
					aint_q <= AINT_HI[11:0];
				else if (aint_sum < AINT_LO)
					aint_q <= AINT_LO[11:0];
				else
					aint_q <= aint_sum[11:0];
			end
			CO_OUTER: outer_q <= sat32(outer_sum);
			CO_FILT: begin
				fold_q <= filt_q;
				filt_q <= fsum[47:16];
			end
			CO_RATE_INT: begin
				if (rint_sum > RINT_HI)
					rint_q <= RINT_HI[19:0];
				else if (rint_sum < RINT_LO)
					rint_q <= RINT_LO[19:0];
				else
					rint_q <= rint_sum[19:0];
			end
			CO_SUM: begin
				if (dsum > lim_pos)
					hold_q <= lim_pos[23:0];
				else if (dsum < lim_neg)
					hold_q <= lim_neg[23:0];
				else
					hold_q <= dsum[23:0];
			end
			default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (cmd.ld_in) begin
			err_q  <= {sample.tilt_angle[23], sample.tilt_angle}
				- {cfg.angle_setpoint[23], cfg.angle_setpoint};
			rate_q <= sample.pitch_rate;
		end
		case (cmd.cons_op)
		CO_ACC_AINT: acc_q <= rnd64 + {{52{aint_q[11]}}, aint_q};
		CO_ACC_RAW:  acc_q <= prod_s1;
		CO_ACC_RINT: acc_q <= rnd64 + {{44{rint_q[19]}}, rint_q};
		default: ;
		endcase
		if (cmd.ld_diff)
			diff_q <= sat32({{32{outer_q[31]}}, outer_q} - {{40{rate_q[23]}}, rate_q});
		if (cmd.ld_delta)
			delta_q <= sat32({{32{filt_q[31]}}, filt_q} - {{32{fold_q[31]}}, fold_q});
		if (cmd.ld_out) begin
			result_q.drive         <= hold_q;
			result_q.outer_updated <= cmd.upd;
		end
	end

	assign result = result_q;

endmodule
